// ===== rtl/tdpi_pkg.sv =====
// ----------------------------------------------------------------------------
// tdpi_pkg
// Shared constants, the arctangent table and the controller/datapath
// command and status types of the tilt driven position integrator.
// ----------------------------------------------------------------------------
package tdpi_pkg;

	localparam int WHOLE_BITS     = 12;
	localparam int TILT_BITS      = 16;
	localparam int CORDIC_STEPS   = 21;
	localparam int CORDIC_BITS    = 32;
	localparam int ANGLE_BITS     = 25;
	localparam int ATAN_BITS      = 22;
	localparam int PMAG_BITS      = 15;
	localparam int PITCH_LIMIT    = 23040;
	localparam int ROOT_BITS      = 28;
	localparam int RAD_BITS       = 56;
	localparam int CUBE_DIVISOR   = 7000;
	// 7000 = 875 << 3: shift off the power of two, reciprocal for the rest
	localparam int CUBE_ODD       = 875;
	localparam int CUBE_ODD_SHIFT = 3;
	localparam int CUBE_ODD_BITS  = 10;
	localparam int CUBE_BITS      = 45;
	localparam int CUBE_SCALE     = 24;
	localparam int CFG_DATA_BITS  = 12;
	localparam int CFG_IDX_BITS   = 2;
	localparam int STEP_BITS      = 5;

	localparam logic [CFG_IDX_BITS-1:0] CFG_LEFT   = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT  = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_MARGIN = 2'd2;

	typedef struct packed {
		logic capture;
		logic win;
		logic div5_step;
		logic square;
		logic sqrt_load;
		logic sqrt_step;
		logic cord_load;
		logic cord_step;
		logic round_p;
		logic cube2;
		logic cube3;
		logic div7_load;
		logic div7_step;
		logic finish_sample;
		logic finish_load;
		logic [STEP_BITS-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} status_t;

	// atan(2^-k) in degrees * 2^16, rounded to nearest
	function automatic logic [ATAN_BITS-1:0] atan_entry(input logic [STEP_BITS-1:0] k);
		logic [ATAN_BITS-1:0] v;
		unique case (k)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/tdpi_ctrl.sv =====
// ----------------------------------------------------------------------------
// tdpi_ctrl
// Sequencer: steps the datapath through window update, averaging, root,
// CORDIC, cube, divide and clamp, one phase after another, or loads a position.
// ----------------------------------------------------------------------------
module tdpi_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             mode,
	output tdpi_pkg::cmd_t   cmd,
	input  tdpi_pkg::status_t status
);

	localparam int SQRT_STEPS = tdpi_pkg::RAD_BITS / 2;
	localparam int CNT_BITS   = 6;

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_WIN    = 4'd1;
	localparam logic [3:0] ST_DIV5   = 4'd2;
	localparam logic [3:0] ST_SQUARE = 4'd3;
	localparam logic [3:0] ST_SQLOAD = 4'd4;
	localparam logic [3:0] ST_SQRT   = 4'd5;
	localparam logic [3:0] ST_CLOAD  = 4'd6;
	localparam logic [3:0] ST_CORD   = 4'd7;
	localparam logic [3:0] ST_ROUND  = 4'd8;
	localparam logic [3:0] ST_CUBE2  = 4'd9;
	localparam logic [3:0] ST_CUBE3  = 4'd10;
	localparam logic [3:0] ST_DLOAD  = 4'd11;
	localparam logic [3:0] ST_DIV7   = 4'd12;
	localparam logic [3:0] ST_FINISH = 4'd13;
	localparam logic [3:0] ST_LOAD   = 4'd14;

	logic [3:0]          state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic                accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		cmd.step = cnt_q[tdpi_pkg::STEP_BITS-1:0];
		cmd.capture = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = mode ? ST_LOAD : ST_WIN;
				end
			end
			ST_WIN: begin
				cmd.win = 1'b1;
				cnt_d   = '0;
				state_d = ST_DIV5;
			end
			ST_DIV5: begin
				cmd.div5_step = 1'b1;
				state_d       = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_SQLOAD;
			end
			ST_SQLOAD: begin
				cmd.sqrt_load = 1'b1;
				cnt_d         = '0;
				state_d       = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == CNT_BITS'(SQRT_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_CLOAD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CLOAD: begin
				cmd.cord_load = 1'b1;
				cnt_d         = '0;
				state_d       = ST_CORD;
			end
			ST_CORD: begin
				cmd.cord_step = 1'b1;
				if (cnt_q == CNT_BITS'(tdpi_pkg::CORDIC_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = ST_ROUND;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_ROUND: begin
				cmd.round_p = 1'b1;
				state_d     = ST_CUBE2;
			end
			ST_CUBE2: begin
				cmd.cube2 = 1'b1;
				state_d   = ST_CUBE3;
			end
			ST_CUBE3: begin
				cmd.cube3 = 1'b1;
				state_d   = ST_DLOAD;
			end
			ST_DLOAD: begin
				cmd.div7_load = 1'b1;
				cnt_d         = '0;
				state_d       = ST_DIV7;
			end
			ST_DIV7: begin
				cmd.div7_step = 1'b1;
				state_d       = ST_FINISH;
			end
			ST_FINISH: begin
				if (!status.out_busy) begin
					cmd.finish_sample = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			ST_LOAD: begin
				if (!status.out_busy) begin
					cmd.finish_load = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// ===== rtl/tdpi_datapath.sv =====
// ----------------------------------------------------------------------------
// tdpi_datapath
// Sample window with running sums, reciprocal averaging, bit-pair square
// root, CORDIC angle unit, cube and reciprocal divide, clamp and output
// register.
// ----------------------------------------------------------------------------
module tdpi_datapath #(
	parameter int WINDOW                 = 5,
	parameter int SAMPLE_BITS            = 16,
	parameter int POSITION_FRACTION_BITS = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  tdpi_pkg::cmd_t                       cmd,
	output tdpi_pkg::status_t                    status,
	input  logic signed [SAMPLE_BITS-1:0]        accel_x,
	input  logic signed [SAMPLE_BITS-1:0]        accel_y,
	input  logic signed [SAMPLE_BITS-1:0]        accel_z,
	input  logic [tdpi_pkg::WHOLE_BITS-1:0]      load_value,
	input  logic                                 cfg_we,
	input  logic [tdpi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [tdpi_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [tdpi_pkg::WHOLE_BITS-1:0]      position,
	output logic signed [tdpi_pkg::TILT_BITS-1:0] tilt_angle,
	output logic                                 at_limit
);

	localparam int SB       = SAMPLE_BITS;
	localparam int F        = POSITION_FRACTION_BITS;
	localparam int SLOT_BITS = $clog2(WINDOW);
	localparam int SUMW     = SB + SLOT_BITS;
	localparam int K5       = SUMW + SLOT_BITS;
	localparam logic [63:0] M5 = ((64'd1 << K5) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
	localparam int PRE_SHIFT = 28 - SB;
	localparam int POS_BITS = tdpi_pkg::WHOLE_BITS + F;
	localparam int NW       = tdpi_pkg::CUBE_BITS - tdpi_pkg::CUBE_SCALE + F;
	localparam int D8W      = NW - tdpi_pkg::CUBE_ODD_SHIFT;
	localparam int K7       = D8W + tdpi_pkg::CUBE_ODD_BITS;
	localparam int QW       = D8W - (tdpi_pkg::CUBE_ODD_BITS - 1);
	localparam logic [63:0] M7 = ((64'd1 << K7) + 64'(tdpi_pkg::CUBE_ODD) - 64'd1) /
		64'(tdpi_pkg::CUBE_ODD);
	localparam int CW       = POS_BITS + 3;
	localparam int CB       = tdpi_pkg::CORDIC_BITS;
	localparam int AB       = tdpi_pkg::ANGLE_BITS;
	localparam int PB       = tdpi_pkg::PMAG_BITS;
	localparam int RB       = tdpi_pkg::ROOT_BITS;
	localparam int DB       = tdpi_pkg::RAD_BITS;

	// configuration
	logic [11:0] left_q, right_q;
	logic [9:0]  margin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= 12'd0;
			right_q  <= 12'd319;
			margin_q <= 10'd20;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdpi_pkg::CFG_LEFT:   left_q   <= cfg_data;
				tdpi_pkg::CFG_RIGHT:  right_q  <= cfg_data;
				tdpi_pkg::CFG_MARGIN: margin_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// input capture
	logic [SB-1:0] in_q [3];
	logic [11:0]   load_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q[0] <= accel_x;
			in_q[1] <= accel_y;
			in_q[2] <= accel_z;
			load_q  <= load_value;
		end
	end

	// window, running sums and averaging by reciprocal multiply
	logic [SB-1:0]          win_q [WINDOW][3];
	logic [SLOT_BITS-1:0]   slot_q;
	logic signed [SUMW-1:0] sum_q [3];
	logic signed [SUMW-1:0] sum_n [3];
	logic [SUMW-1:0]        dq_q [3];
	logic                   neg_q [3];
	logic [SUMW+K5-1:0]     prod5 [3];
	logic [SUMW-1:0]        qv [3];
	logic signed [SB-1:0]   avg [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sum_n[a] = sum_q[a] + SUMW'($signed(in_q[a])) - SUMW'($signed(win_q[slot_q][a]));
			prod5[a] = dq_q[a] * M5[K5-1:0];
			qv[a]    = neg_q[a] ? (SUMW'(0) - dq_q[a]) : dq_q[a];
			avg[a]   = $signed(qv[a][SB-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			for (int a = 0; a < 3; a++) begin
				sum_q[a] <= '0;
			end
			for (int k = 0; k < WINDOW; k++) begin
				for (int a = 0; a < 3; a++) begin
					win_q[k][a] <= '0;
				end
			end
		end else if (cmd.win) begin
			for (int a = 0; a < 3; a++) begin
				sum_q[a]          <= sum_n[a];
				win_q[slot_q][a]  <= in_q[a];
			end
			slot_q <= (slot_q == SLOT_BITS'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	// magnitude first, quotient replaces it, sign restored in qv
	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			if (cmd.win) begin
				neg_q[a] <= sum_n[a][SUMW-1];
				dq_q[a]  <= sum_n[a][SUMW-1] ? (SUMW'(0) - sum_n[a]) : sum_n[a];
			end else if (cmd.div5_step) begin
				dq_q[a] <= SUMW'(prod5[a] >> K5);
			end
		end
	end

	// squares and square root
	logic [2*SB-1:0]      ysq_q, zsq_q;
	logic signed [CB-1:0] yinit_q;
	logic signed [2*SB-1:0] ysq_p, zsq_p;
	logic signed [CB-1:0] yneg;
	logic [DB-1:0]        rad_q;
	logic [RB+1:0]        rem_q;
	logic [RB-1:0]        root_q;
	logic [RB+3:0]        st, strial;
	logic                 sge;

	assign ysq_p  = avg[1] * avg[1];
	assign zsq_p  = avg[2] * avg[2];
	assign yneg   = CB'(0) - CB'(avg[0]);
	assign st     = {rem_q, rad_q[DB-1:DB-2]};
	assign strial = {2'b00, root_q, 2'b01};
	assign sge    = (st >= strial);

	always_ff @(posedge clk) begin
		if (cmd.square) begin
			ysq_q   <= ysq_p;
			zsq_q   <= zsq_p;
			yinit_q <= yneg <<< PRE_SHIFT;
		end
		if (cmd.sqrt_load) begin
			rad_q  <= {ysq_q + zsq_q, {(2*PRE_SHIFT){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[DB-3:0], 2'b00};
			rem_q  <= sge ? (RB+2)'(st - strial) : st[RB+1:0];
			root_q <= {root_q[RB-2:0], sge};
		end
	end

	// CORDIC vectoring
	logic signed [CB-1:0] xv_q, yv_q, xs, ys;
	logic signed [AB-1:0] ang_q, atan_v;
	logic                 zero_q;

	assign xs     = xv_q >>> cmd.step;
	assign ys     = yv_q >>> cmd.step;
	assign atan_v = $signed(AB'(tdpi_pkg::atan_entry(cmd.step)));

	always_ff @(posedge clk) begin
		if (cmd.cord_load) begin
			xv_q   <= $signed(CB'(root_q));
			yv_q   <= yinit_q;
			ang_q  <= '0;
			zero_q <= (root_q == '0) && (yinit_q == '0);
		end else if (cmd.cord_step) begin
			if (!yv_q[CB-1]) begin
				xv_q  <= xv_q + ys;
				yv_q  <= yv_q - xs;
				ang_q <= ang_q + atan_v;
			end else begin
				xv_q  <= xv_q - ys;
				yv_q  <= yv_q + xs;
				ang_q <= ang_q - atan_v;
			end
		end
	end

	// round, saturate, cube, divide by 7000
	logic [AB-1:0]        amag, around;
	logic [PB-1:0]        psat;
	logic [PB-1:0]        pmag_q;
	logic signed [15:0]   p_q;
	logic [2*PB-1:0]      p2_q;
	logic [tdpi_pkg::CUBE_BITS-1:0] p3_q;
	logic [D8W-1:0]       cn_q;
	logic [QW-1:0]        cq_q;
	logic [2*D8W:0]       cprod;

	assign amag   = ang_q[AB-1] ? AB'(AB'(0) - ang_q) : AB'(ang_q);
	assign around = amag + AB'(128);
	assign psat   = (around[AB-1:8] > (AB-8)'(tdpi_pkg::PITCH_LIMIT)) ?
		PB'(tdpi_pkg::PITCH_LIMIT) : around[PB+7:8];
	assign cprod  = cn_q * M7[D8W:0];

	always_ff @(posedge clk) begin
		if (cmd.round_p) begin
			pmag_q <= zero_q ? '0 : psat;
			p_q    <= zero_q ? '0 :
				(ang_q[AB-1] ? $signed(16'(16'd0 - {1'b0, psat})) : $signed({1'b0, psat}));
		end
		if (cmd.cube2) begin
			p2_q <= pmag_q * pmag_q;
		end
		if (cmd.cube3) begin
			p3_q <= p2_q * pmag_q;
		end
		if (cmd.div7_load) begin
			cn_q <= D8W'(p3_q >> (tdpi_pkg::CUBE_SCALE - F + tdpi_pkg::CUBE_ODD_SHIFT));
		end
		if (cmd.div7_step) begin
			cq_q <= QW'(cprod >> K7);
		end
	end

	// clamp
	logic [POS_BITS-1:0]  paddle_q;
	logic signed [CW-1:0] inc, pos0, hi, lo, pos1, pos2, pos3;
	logic                 clip;

	always_comb begin
		inc  = $signed(CW'(cq_q));
		pos0 = $signed(CW'(paddle_q)) + (p_q[15] ? inc : (CW'(0) - inc));
		hi   = ($signed(CW'(right_q)) - $signed(CW'(margin_q)) - CW'(1)) <<< F;
		lo   = ($signed(CW'(left_q)) + $signed(CW'(margin_q)) + CW'(1)) <<< F;
		clip = 1'b0;
		pos1 = pos0;
		if (pos0 > hi) begin
			pos1 = hi;
			clip = 1'b1;
		end
		pos2 = pos1;
		if (pos1 < lo) begin
			pos2 = lo;
			clip = 1'b1;
		end
		pos3 = pos2;
		if (pos2 > $signed(CW'({POS_BITS{1'b1}}))) begin
			pos3 = $signed(CW'({POS_BITS{1'b1}}));
			clip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paddle_q <= '0;
		end else if (cmd.finish_sample) begin
			paddle_q <= pos3[POS_BITS-1:0];
		end else if (cmd.finish_load) begin
			paddle_q <= POS_BITS'(load_q) << F;
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish_sample || cmd.finish_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish_sample) begin
			position   <= pos3[POS_BITS-1:F];
			tilt_angle <= p_q;
			at_limit   <= clip;
		end else if (cmd.finish_load) begin
			position   <= load_q;
			tilt_angle <= '0;
			at_limit   <= 1'b0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status.out_busy = out_valid_q && !out_ready;

endmodule

// ===== rtl/tilt_driven_position_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// tilt_driven_position_integrator_unit
// Sample beats run a 28-step bit-pair root and a 21-step CORDIC before the
// result is registered; load beats only load the position. One item in
// flight; the next beat is taken while a result waits. Asynchronous reset
// clears window, sums, slot, paddle position, configuration and valid flag.
// ----------------------------------------------------------------------------
module tilt_driven_position_integrator_unit #(
	parameter int WINDOW                 = 5,
	parameter int SAMPLE_BITS            = 16,
	parameter int POSITION_FRACTION_BITS = 8
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  mode,
	input  logic signed [SAMPLE_BITS-1:0]         accel_x,
	input  logic signed [SAMPLE_BITS-1:0]         accel_y,
	input  logic signed [SAMPLE_BITS-1:0]         accel_z,
	input  logic [tdpi_pkg::WHOLE_BITS-1:0]       load_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [tdpi_pkg::WHOLE_BITS-1:0]       position,
	output logic signed [tdpi_pkg::TILT_BITS-1:0] tilt_angle,
	output logic                                  at_limit,
	input  logic                                  cfg_we,
	input  logic [tdpi_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [tdpi_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	tdpi_pkg::cmd_t    cmd;
	tdpi_pkg::status_t status;

	tdpi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.cmd      (cmd),
		.status   (status)
	);

	tdpi_datapath #(
		.WINDOW                 (WINDOW),
		.SAMPLE_BITS            (SAMPLE_BITS),
		.POSITION_FRACTION_BITS (POSITION_FRACTION_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.load_value (load_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.position   (position),
		.tilt_angle (tilt_angle),
		.at_limit   (at_limit)
	);

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives sample and load beats into the tilt driven position integrator,
// predicts window averages, CORDIC pitch, cubic drift and clamping per beat,
// and checks every result beat against the prediction in order.
// ----------------------------------------------------------------------------
module tb_top;

	typedef struct packed {
		logic        mode;
		logic [15:0] ax;
		logic [15:0] ay;
		logic [15:0] az;
		logic [11:0] load;
	} sample_t;

	typedef struct packed {
		logic [11:0] pos;
		logic [15:0] tilt;
		logic        lim;
	} pos_result_t;

	logic clk, arst_n;
	logic in_valid, in_ready, mode;
	logic signed [15:0] accel_x, accel_y, accel_z;
	logic [11:0] load_value;
	logic out_valid, out_ready;
	logic [11:0] position;
	logic signed [15:0] tilt_angle;
	logic at_limit;
	logic cfg_we;
	logic [tdpi_pkg::CFG_IDX_BITS-1:0] cfg_index;
	logic [tdpi_pkg::CFG_DATA_BITS-1:0] cfg_data;

	tilt_driven_position_integrator_unit dut (.*);

	sample_t     pending_q[$];
	pos_result_t expected_q[$];
	int mismatches, results_seen, in_gap, out_gap, hold_cycles;
	bit quiet, hold_req;

	// predictor state
	longint win_x[5], win_y[5], win_z[5];
	int     slot;
	longint pos_q;
	longint lim_left, lim_right, lim_margin;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(longint n);
		longint r, b;
		r = 0;
		b = 64'sd1 <<< 62;
		while (b > n) b = b >>> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint pitch_of(longint mx, longint my, longint mz);
		longint xv, yv, nx, ny, ang;
		xv = root_floor((my * my + mz * mz) << 24);
		yv = -mx * 4096;
		ang = 0;
		if (xv == 0 && yv == 0) return 0;
		for (int k = 0; k < tdpi_pkg::CORDIC_STEPS; k++) begin
			if (yv >= 0) begin
				nx = xv + shr_floor(yv, k);
				ny = yv - shr_floor(xv, k);
				ang += longint'(tdpi_pkg::atan_entry(k[tdpi_pkg::STEP_BITS-1:0]));
			end else begin
				nx = xv - shr_floor(yv, k);
				ny = yv + shr_floor(xv, k);
				ang -= longint'(tdpi_pkg::atan_entry(k[tdpi_pkg::STEP_BITS-1:0]));
			end
			xv = nx;
			yv = ny;
		end
		ang = (ang >= 0) ? (ang + 128) / 256 : -((-ang + 128) / 256);
		if (ang > tdpi_pkg::PITCH_LIMIT) ang = tdpi_pkg::PITCH_LIMIT;
		if (ang < -tdpi_pkg::PITCH_LIMIT) ang = -tdpi_pkg::PITCH_LIMIT;
		return ang;
	endfunction

	function automatic pos_result_t drift_step(sample_t s);
		pos_result_t r;
		longint sx, sy, sz, p, inc, hi, lo, np;
		bit clip;
		clip = 0;
		p = 0;
		if (s.mode) begin
			pos_q = longint'(s.load) << 8;
		end else begin
			win_x[slot] = longint'(signed'(s.ax));
			win_y[slot] = longint'(signed'(s.ay));
			win_z[slot] = longint'(signed'(s.az));
			slot = (slot + 1 >= 5) ? 0 : slot + 1;
			sx = 0; sy = 0; sz = 0;
			for (int k = 0; k < 5; k++) begin
				sx += win_x[k]; sy += win_y[k]; sz += win_z[k];
			end
			p = pitch_of(sx / 5, sy / 5, sz / 5);
			inc = (p * p * p * 256) / (longint'(tdpi_pkg::CUBE_DIVISOR) <<< 24);
			np = pos_q - inc;
			hi = (lim_right - lim_margin - 1) * 256;
			lo = (lim_left + lim_margin + 1) * 256;
			if (np > hi) begin np = hi; clip = 1; end
			if (np < lo) begin np = lo; clip = 1; end
			if (np > 1048575) begin np = 1048575; clip = 1; end
			pos_q = np;
		end
		r.pos = pos_q[19:8];
		r.tilt = p[15:0];
		r.lim = clip;
		return r;
	endfunction

	task automatic write_reg(logic [tdpi_pkg::CFG_IDX_BITS-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val[tdpi_pkg::CFG_DATA_BITS-1:0];
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			tdpi_pkg::CFG_LEFT:   lim_left = longint'(val & 12'hFFF);
			tdpi_pkg::CFG_RIGHT:  lim_right = longint'(val & 12'hFFF);
			tdpi_pkg::CFG_MARGIN: lim_margin = longint'(val & 10'h3FF);
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	function automatic sample_t rand_sample(bit small_mag);
		sample_t s;
		s.mode = ($urandom_range(0, 15) == 0);
		if (small_mag) begin
			s.ax = 16'($signed($urandom_range(0, 4000)) - 2000);
			s.ay = 16'($signed($urandom_range(0, 4000)) - 2000);
			s.az = 16'($signed($urandom_range(0, 4000)) - 2000);
		end else begin
			s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
		end
		s.load = 12'($urandom);
		return s;
	endfunction

	function automatic sample_t mk(bit m, int x, int y, int z, int l);
		sample_t s;
		s.mode = m; s.ax = x[15:0]; s.ay = y[15:0]; s.az = z[15:0]; s.load = l[11:0];
		return s;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			in_gap <= 0;
		end else if (in_valid && !in_ready) begin
		end else if (in_gap > 0) begin
			in_gap <= in_gap - 1;
			in_valid <= 0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			in_gap <= $urandom_range(0, 5);
			in_valid <= 0;
		end else if (pending_q.size() != 0) begin
			sample_t s;
			s = pending_q.pop_front();
			in_valid <= 1;
			mode <= s.mode; accel_x <= s.ax; accel_y <= s.ay;
			accel_z <= s.az; load_value <= s.load;
			expected_q.push_back(drift_step(s));
		end else begin
			in_valid <= 0;
		end
	end

	// result stall control
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 0;
			out_gap <= 0;
			hold_cycles <= 0;
		end else if (hold_req && hold_cycles == 0) begin
			hold_cycles <= 600;
			out_ready <= 0;
		end else if (hold_cycles > 1) begin
			hold_cycles <= hold_cycles - 1;
		end else if (hold_cycles == 1) begin
			hold_cycles <= -1;
			out_ready <= 1;
		end else if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_ready <= (out_gap == 1);
		end else if (!quiet && $urandom_range(0, 5) == 0) begin
			out_gap <= $urandom_range(1, 6);
			out_ready <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			pos_result_t e;
			results_seen <= results_seen + 1;
			if (expected_q.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected result beat pos=%0d", position);
			end else begin
				e = expected_q.pop_front();
				if (e.pos !== position || e.tilt !== tilt_angle || e.lim !== at_limit) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("mismatch: exp pos=%0d tilt=%0d lim=%0b, got pos=%0d tilt=%0d lim=%0b",
							e.pos, $signed(e.tilt), e.lim, position, tilt_angle, at_limit);
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		arst_n = 0;
		cfg_we = 0; cfg_index = tdpi_pkg::CFG_LEFT; cfg_data = 0;
		mode = 0; accel_x = 0; accel_y = 0; accel_z = 0; load_value = 0;
		mismatches = 0; results_seen = 0; quiet = 0; hold_req = 0;
		for (int k = 0; k < 5; k++) begin win_x[k] = 0; win_y[k] = 0; win_z[k] = 0; end
		slot = 0; pos_q = 0; lim_left = 0; lim_right = 319; lim_margin = 20;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// directed: zero vector, extremes, loads, clamp on both sides
		pending_q.push_back(mk(0, 0, 0, 0, 0));
		pending_q.push_back(mk(1, 0, 0, 0, 4095));
		pending_q.push_back(mk(0, 32767, 0, 0, 0));
		pending_q.push_back(mk(0, -32768, 0, 0, 0));
		pending_q.push_back(mk(0, -32768, -32768, -32768, 0));
		pending_q.push_back(mk(0, 32767, 32767, 32767, 4095));
		pending_q.push_back(mk(0, 0, -32768, 32767, 0));
		pending_q.push_back(mk(1, 0, 0, 0, 0));
		for (int k = 0; k < 6; k++) pending_q.push_back(mk(0, -32768, 100, 100, 0));
		pending_q.push_back(mk(1, 0, 0, 0, 160));
		for (int k = 0; k < 6; k++) pending_q.push_back(mk(0, 32767, -100, 5, 0));
		drain();

		// crossed bounds, lower wins; then bound above the storable range
		write_reg(tdpi_pkg::CFG_LEFT, 3000);
		write_reg(tdpi_pkg::CFG_RIGHT, 100);
		write_reg(tdpi_pkg::CFG_MARGIN, 1023);
		pending_q.push_back(mk(0, 5, 5, 5, 0));
		pending_q.push_back(mk(1, 0, 0, 0, 77));
		pending_q.push_back(mk(0, 0, 0, 0, 0));
		drain();
		write_reg(tdpi_pkg::CFG_LEFT, 4095);
		write_reg(tdpi_pkg::CFG_MARGIN, 0);
		pending_q.push_back(mk(0, 1, 2, 3, 0));
		drain();

		// random phases across several travel ranges
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin write_reg(tdpi_pkg::CFG_LEFT, 0); write_reg(tdpi_pkg::CFG_RIGHT, 4095);
					write_reg(tdpi_pkg::CFG_MARGIN, 0); end
				1: begin write_reg(tdpi_pkg::CFG_LEFT, 0); write_reg(tdpi_pkg::CFG_RIGHT, 319);
					write_reg(tdpi_pkg::CFG_MARGIN, 20); end
				2: begin write_reg(tdpi_pkg::CFG_LEFT, $urandom_range(0, 2000));
					write_reg(tdpi_pkg::CFG_RIGHT, $urandom_range(0, 4095));
					write_reg(tdpi_pkg::CFG_MARGIN, $urandom_range(0, 1023)); end
				default: begin write_reg(tdpi_pkg::CFG_LEFT, 100);
					write_reg(tdpi_pkg::CFG_RIGHT, 3000);
					write_reg(tdpi_pkg::CFG_MARGIN, 5); end
			endcase
			if (ph == 3) quiet = 1;
			for (int k = 0; k < 120; k++) pending_q.push_back(rand_sample(k % 3 != 0));
			if (ph == 1) begin
				hold_req = 1;
				while (hold_cycles == 0) @(posedge clk);
				hold_req = 0;
			end
			drain();
		end

		$display("covered %0d result beats over directed, crossed-bound and 4 random phases",
			results_seen);
		$display("long result stall and random idling on both sides exercised");
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("tb_top passed");
		end else begin
			$display("tb_top failed");
		end
		$finish;
	end
endmodule

// ===== tilt_driven_position_integrator_unit.f =====
rtl/tdpi_pkg.sv
rtl/tdpi_ctrl.sv
rtl/tdpi_datapath.sv
rtl/tilt_driven_position_integrator_unit.sv
verif/tb_top.sv
